### hdl/tps_pkg.sv
package tps_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_ABORT = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ORIENT  = 2'd1,
    PH_EXECUTE = 2'd2,
    PH_OUTCOME = 2'd3
  } phase_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic [DataW-1:0] res;
    logic             ge;
  } alu_out_t;

endpackage

### hdl/tps_alu.sv
module tps_alu (
  input  tps_pkg::alu_op_e            op_i,
  input  logic [tps_pkg::DataW-1:0]   a_i,
  input  logic [tps_pkg::DataW-1:0]   b_i,
  output tps_pkg::alu_out_t           out_o
);

  logic [tps_pkg::DataW-1:0] b_eff;
  logic [tps_pkg::DataW:0]   sum;
  logic                      sub;

  assign sub   = (op_i == tps_pkg::ALU_SUB);
  assign b_eff = sub ? ~b_i : b_i;
  assign sum   = {1'b0, a_i} + {1'b0, b_eff} + {{tps_pkg::DataW{1'b0}}, sub};

  // For a subtract, the carry out is set exactly when a >= b (unsigned).
  assign out_o.res = sum[tps_pkg::DataW-1:0];
  assign out_o.ge  = sub & sum[tps_pkg::DataW];

endmodule

### hdl/timed_phase_sequencer_with_cooldown_top.sv
// Abort, the unused code and a start while running go straight to S_FIN; a start
// while idle first does the cooldown compare (S_CHK); a tick adds the delta (S_TIME),
// then S_ELAP and, unless idle, S_CMP; an ended phase advances (S_ADV), orient and
// execute then rerun S_ELAP, outcome adds the deadline (S_COOL); all on one shared adder.
// Input is taken only in S_IDLE; S_FIN waits for a free result register, which lets
// the next word enter while a result waits. Reset (asynchronous, active low) clears control state.
module timed_phase_sequencer_with_cooldown_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] delta_ms_i,
  input  logic [31:0] orient_len_i,
  input  logic [31:0] execute_len_i,
  input  logic [31:0] outcome_len_i,
  input  logic [31:0] cooldown_len_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  phase_now_o,
  output logic        is_running_o,
  output logic        is_cooling_o,
  output logic        start_ok_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TIME,
    S_ELAP,
    S_CMP,
    S_ADV,
    S_COOL,
    S_CHK,
    S_FIN
  } state_e;

  state_e                    state_q, state_d;
  tps_pkg::phase_e           phase_q, phase_d;
  logic [31:0]               time_q, time_d;
  logic [31:0]               begin_q, begin_d;
  logic [31:0]               deadline_q, deadline_d;
  logic [31:0]               orient_dur_q, orient_dur_d;
  logic [31:0]               execute_dur_q, execute_dur_d;
  logic [31:0]               outcome_dur_q, outcome_dur_d;
  logic [31:0]               cooldown_dur_q, cooldown_dur_d;
  logic [31:0]               elapsed_q, elapsed_d;
  logic                      ok_q, ok_d;

  logic [31:0]               delta_q, delta_d;
  logic [31:0]               orient_len_q, orient_len_d;
  logic [31:0]               execute_len_q, execute_len_d;
  logic [31:0]               outcome_len_q, outcome_len_d;
  logic [31:0]               cooldown_len_q, cooldown_len_d;

  logic                      out_valid_q, out_valid_d;
  logic [1:0]                phase_now_q, phase_now_d;
  logic                      is_running_q, is_running_d;
  logic                      is_cooling_q, is_cooling_d;
  logic                      start_ok_q, start_ok_d;

  tps_pkg::alu_op_e          alu_op;
  logic [31:0]               alu_a, alu_b;
  tps_pkg::alu_out_t         alu_out;
  logic [31:0]               cur_dur;

  tps_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .out_o (alu_out)
  );

  always_comb begin
    case (phase_q)
      tps_pkg::PH_ORIENT:  cur_dur = orient_dur_q;
      tps_pkg::PH_EXECUTE: cur_dur = execute_dur_q;
      default:             cur_dur = outcome_dur_q;
    endcase
  end

  always_comb begin
    alu_op = tps_pkg::ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state_q)
      S_TIME: begin
        alu_a = time_q;
        alu_b = delta_q;
      end
      S_ELAP: begin
        alu_op = tps_pkg::ALU_SUB;
        alu_a  = time_q;
        alu_b  = begin_q;
      end
      S_CMP: begin
        alu_op = tps_pkg::ALU_SUB;
        alu_a  = elapsed_q;
        alu_b  = cur_dur;
      end
      S_ADV: begin
        alu_a = begin_q;
        alu_b = cur_dur;
      end
      S_COOL: begin
        alu_a = time_q;
        alu_b = cooldown_dur_q;
      end
      S_CHK, S_FIN: begin
        alu_op = tps_pkg::ALU_SUB;
        alu_a  = time_q;
        alu_b  = deadline_q;
      end
      default: begin
        alu_op = tps_pkg::ALU_ADD;
      end
    endcase
  end

  always_comb begin
    state_d        = state_q;
    phase_d        = phase_q;
    time_d         = time_q;
    begin_d        = begin_q;
    deadline_d     = deadline_q;
    orient_dur_d   = orient_dur_q;
    execute_dur_d  = execute_dur_q;
    outcome_dur_d  = outcome_dur_q;
    cooldown_dur_d = cooldown_dur_q;
    elapsed_d      = elapsed_q;
    ok_d           = ok_q;
    delta_d        = delta_q;
    orient_len_d   = orient_len_q;
    execute_len_d  = execute_len_q;
    outcome_len_d  = outcome_len_q;
    cooldown_len_d = cooldown_len_q;
    out_valid_d    = out_valid_q & ~out_ready_i;
    phase_now_d    = phase_now_q;
    is_running_d   = is_running_q;
    is_cooling_d   = is_cooling_q;
    start_ok_d     = start_ok_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          delta_d        = delta_ms_i;
          orient_len_d   = orient_len_i;
          execute_len_d  = execute_len_i;
          outcome_len_d  = outcome_len_i;
          cooldown_len_d = cooldown_len_i;
          ok_d           = 1'b0;
          case (tps_pkg::opcode_e'(opcode_i))
            tps_pkg::OP_TICK: state_d = S_TIME;
            tps_pkg::OP_START: begin
              state_d = (phase_q == tps_pkg::PH_IDLE) ? S_CHK : S_FIN;
            end
            tps_pkg::OP_ABORT: begin
              phase_d = tps_pkg::PH_IDLE;
              state_d = S_FIN;
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_TIME: begin
        time_d  = alu_out.res;
        state_d = S_ELAP;
      end
      S_ELAP: begin
        elapsed_d = alu_out.res;
        state_d   = (phase_q == tps_pkg::PH_IDLE) ? S_FIN : S_CMP;
      end
      S_CMP: begin
        state_d = alu_out.ge ? S_ADV : S_FIN;
      end
      S_ADV: begin
        begin_d = alu_out.res;
        if (phase_q == tps_pkg::PH_OUTCOME) begin
          phase_d = tps_pkg::PH_IDLE;
          state_d = S_COOL;
        end else begin
          phase_d = tps_pkg::phase_e'(2'(phase_q) + 2'd1);
          state_d = S_ELAP;
        end
      end
      S_COOL: begin
        deadline_d = alu_out.res;
        state_d    = S_FIN;
      end
      S_CHK: begin
        // Not cooling when time has reached the deadline.
        if (alu_out.ge) begin
          phase_d        = tps_pkg::PH_ORIENT;
          begin_d        = time_q;
          orient_dur_d   = orient_len_q;
          execute_dur_d  = execute_len_q;
          outcome_dur_d  = outcome_len_q;
          cooldown_dur_d = cooldown_len_q;
          ok_d           = 1'b1;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          phase_now_d  = 2'(phase_q);
          is_running_d = (phase_q != tps_pkg::PH_IDLE);
          is_cooling_d = (phase_q == tps_pkg::PH_IDLE) && !alu_out.ge;
          start_ok_d   = ok_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      phase_q        <= tps_pkg::PH_IDLE;
      time_q         <= '0;
      begin_q        <= '0;
      deadline_q     <= '0;
      orient_dur_q   <= '0;
      execute_dur_q  <= '0;
      outcome_dur_q  <= '0;
      cooldown_dur_q <= '0;
      ok_q           <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      phase_q        <= phase_d;
      time_q         <= time_d;
      begin_q        <= begin_d;
      deadline_q     <= deadline_d;
      orient_dur_q   <= orient_dur_d;
      execute_dur_q  <= execute_dur_d;
      outcome_dur_q  <= outcome_dur_d;
      cooldown_dur_q <= cooldown_dur_d;
      ok_q           <= ok_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elapsed_q      <= elapsed_d;
    delta_q        <= delta_d;
    orient_len_q   <= orient_len_d;
    execute_len_q  <= execute_len_d;
    outcome_len_q  <= outcome_len_d;
    cooldown_len_q <= cooldown_len_d;
    phase_now_q    <= phase_now_d;
    is_running_q   <= is_running_d;
    is_cooling_q   <= is_cooling_d;
    start_ok_q     <= start_ok_d;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign phase_now_o  = phase_now_q;
  assign is_running_o = is_running_q;
  assign is_cooling_o = is_cooling_q;
  assign start_ok_o   = start_ok_q;

endmodule

### hdl/tps_checker.sv
module tps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] phase_now_o,
  input logic       is_running_o,
  input logic       is_cooling_o,
  input logic       start_ok_o
);

  // The block works on one word at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while the previous word is still at work");

  a_running_matches_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_running_o == (phase_now_o != 2'(tps_pkg::PH_IDLE))))
    else $error("is_running disagrees with phase_now");

  a_cooling_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_cooling_o |-> !is_running_o)
    else $error("cooling reported while running");

  a_start_enters_orient: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_ok_o |-> phase_now_o == 2'(tps_pkg::PH_ORIENT) && !is_cooling_o)
    else $error("accepted start did not leave the block in orient");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(phase_now_o)
      && $stable(start_ok_o))
    else $error("stalled result changed");

endmodule

bind timed_phase_sequencer_with_cooldown_top tps_checker u_tps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .phase_now_o  (phase_now_o),
  .is_running_o (is_running_o),
  .is_cooling_o (is_cooling_o),
  .start_ok_o   (start_ok_o)
);

### tb/tb_timed_phase_sequencer_with_cooldown_top.sv
`timescale 1ns / 1ps

module tb_timed_phase_sequencer_with_cooldown_top;

  localparam int unsigned StallLimit = 5000;

  typedef struct {
    tps_pkg::opcode_e op;
    logic [31:0]      delta;
    logic [31:0]      orient;
    logic [31:0]      execute;
    logic [31:0]      outcome;
    logic [31:0]      cooldown;
  } cmd_t;

  typedef struct {
    tps_pkg::phase_e phase;
    logic            running;
    logic            cooling;
    logic            ok;
  } status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = tps_pkg::OP_TICK;
  logic [31:0] delta_ms_i = '0;
  logic [31:0] orient_len_i = '0;
  logic [31:0] execute_len_i = '0;
  logic [31:0] outcome_len_i = '0;
  logic [31:0] cooldown_len_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  phase_now_o;
  logic        is_running_o;
  logic        is_cooling_o;
  logic        start_ok_o;

  timed_phase_sequencer_with_cooldown_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .delta_ms_i    (delta_ms_i),
    .orient_len_i  (orient_len_i),
    .execute_len_i (execute_len_i),
    .outcome_len_i (outcome_len_i),
    .cooldown_len_i(cooldown_len_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .phase_now_o   (phase_now_o),
    .is_running_o  (is_running_o),
    .is_cooling_o  (is_cooling_o),
    .start_ok_o    (start_ok_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  cmd_t    cmd_q[$];
  status_t status_q[$];
  int      errors = 0;

  // Mirror of the sequencer state, updated once per accepted word.
  tps_pkg::phase_e seq_phase = tps_pkg::PH_IDLE;
  logic [31:0] clock_ms = '0;
  logic [31:0] phase_start_ms = '0;
  logic [31:0] cool_until_ms = '0;
  logic [31:0] dur_orient = '0;
  logic [31:0] dur_execute = '0;
  logic [31:0] dur_outcome = '0;
  logic [31:0] dur_cool = '0;

  function automatic logic seq_cooling();
    return seq_phase == tps_pkg::PH_IDLE && clock_ms < cool_until_ms;
  endfunction

  function automatic status_t step_sequencer(input cmd_t c);
    status_t     s;
    logic [31:0] dur;
    logic        settled;
    s.ok = 1'b0;
    case (c.op)
      tps_pkg::OP_TICK: begin
        clock_ms = clock_ms + c.delta;
        settled = 1'b0;
        for (int k = 0; k < 3; k++) begin
          if (!settled) begin
            case (seq_phase)
              tps_pkg::PH_ORIENT:  dur = dur_orient;
              tps_pkg::PH_EXECUTE: dur = dur_execute;
              default:             dur = dur_outcome;
            endcase
            if (seq_phase == tps_pkg::PH_IDLE || clock_ms - phase_start_ms < dur) begin
              settled = 1'b1;
            end else begin
              // The phase ends exactly on its duration, so leftover time carries on.
              phase_start_ms = phase_start_ms + dur;
              if (seq_phase == tps_pkg::PH_OUTCOME) begin
                seq_phase = tps_pkg::PH_IDLE;
                cool_until_ms = clock_ms + dur_cool;
              end else begin
                seq_phase = tps_pkg::phase_e'(seq_phase + 2'd1);
              end
            end
          end
        end
      end
      tps_pkg::OP_START: begin
        if (seq_phase == tps_pkg::PH_IDLE && !seq_cooling()) begin
          seq_phase = tps_pkg::PH_ORIENT;
          phase_start_ms = clock_ms;
          dur_orient = c.orient;
          dur_execute = c.execute;
          dur_outcome = c.outcome;
          dur_cool = c.cooldown;
          s.ok = 1'b1;
        end
      end
      tps_pkg::OP_ABORT: seq_phase = tps_pkg::PH_IDLE;
      default: ;
    endcase
    s.phase = seq_phase;
    s.running = seq_phase != tps_pkg::PH_IDLE;
    s.cooling = seq_cooling();
    return s;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Input side: present one word at a time from the queue, with random gaps.
  cmd_t        cur_cmd;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  logic        presenting;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      presenting = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        status_q.push_back(step_sequencer(cur_cmd));
        presenting = 1'b0;
      end
      if (!presenting) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          cur_cmd = cmd_q.pop_front();
          opcode_i <= cur_cmd.op;
          delta_ms_i <= cur_cmd.delta;
          orient_len_i <= cur_cmd.orient;
          execute_len_i <= cur_cmd.execute;
          outcome_len_i <= cur_cmd.outcome;
          cooldown_len_i <= cur_cmd.cooldown;
          in_valid_i <= 1'b1;
          if (send_calm != 0) begin
            send_calm--;
          end else begin
            send_gap = gap_len();
            if ($urandom_range(0, 99) < 3) send_calm = $urandom_range(30, 80);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output side: check each word against the oldest prediction, stall at random.
  status_t     want;
  int unsigned recv_gap = 0;
  int unsigned recv_calm = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (status_q.size() == 0) begin
          $display("%0t: unexpected result word phase=%0d", $time, phase_now_o);
          errors++;
        end else begin
          want = status_q.pop_front();
          if (phase_now_o !== want.phase) begin
            $display("%0t: phase_now expected %0d actual %0d", $time, want.phase,
                     phase_now_o);
            errors++;
          end
          if (is_running_o !== want.running) begin
            $display("%0t: is_running expected %0b actual %0b", $time, want.running,
                     is_running_o);
            errors++;
          end
          if (is_cooling_o !== want.cooling) begin
            $display("%0t: is_cooling expected %0b actual %0b", $time, want.cooling,
                     is_cooling_o);
            errors++;
          end
          if (start_ok_o !== want.ok) begin
            $display("%0t: start_ok expected %0b actual %0b", $time, want.ok,
                     start_ok_o);
            errors++;
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (recv_calm != 0) begin
          recv_calm--;
        end else begin
          if ($urandom_range(0, 99) < 30) recv_gap = gap_len();
          if ($urandom_range(0, 99) < 2) recv_calm = $urandom_range(40, 120);
        end
      end
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  task automatic push_cmd(input tps_pkg::opcode_e op, input logic [31:0] delta,
                          input logic [31:0] o, input logic [31:0] e,
                          input logic [31:0] u, input logic [31:0] c);
    cmd_t x;
    x.op = op;
    x.delta = delta;
    x.orient = o;
    x.execute = e;
    x.outcome = u;
    x.cooldown = c;
    cmd_q.push_back(x);
  endtask

  task automatic push_tick(input logic [31:0] delta);
    push_cmd(tps_pkg::OP_TICK, delta, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic push_start(input logic [31:0] o, input logic [31:0] e,
                            input logic [31:0] u, input logic [31:0] c);
    push_cmd(tps_pkg::OP_START, $urandom, o, e, u, c);
  endtask

  function automatic logic [31:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 32'd0;
    if (r < 75) return $urandom_range(1, 12);
    if (r < 88) return $urandom_range(13, 300);
    if (r < 95) return $urandom;
    return 32'hFFFF_FFFF - $urandom_range(0, 3);
  endfunction

  function automatic logic [31:0] pick_cool();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return 32'd0;
    if (r < 85) return $urandom_range(1, 40);
    if (r < 97) return $urandom_range(41, 2000);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_delta();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return 32'd0;
    if (r < 80) return $urandom_range(1, 10);
    if (r < 92) return $urandom_range(11, 200);
    if (r < 97) return $urandom;
    return 32'hFFFF_FFFF - $urandom_range(0, 15);
  endfunction

  int unsigned r;
  int unsigned burst;

  initial begin
    // Directed words: unused code, idle abort, zero durations, extreme lengths,
    // time wrap, refused starts, cooldown with and without wrap of the deadline.
    push_cmd(tps_pkg::OP_NONE, '1, '1, '1, '1, '1);
    push_cmd(tps_pkg::OP_ABORT, '1, '1, '1, '1, '1);
    push_tick(32'd0);
    push_start(32'd0, 32'd0, 32'd0, 32'd0);
    push_tick(32'd0);
    push_start('1, '1, '1, '1);
    push_start(32'd1, 32'd1, 32'd1, 32'd1);
    push_tick(32'hFFFF_FFFF);
    push_cmd(tps_pkg::OP_ABORT, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    push_start(32'd1, 32'd2, 32'd3, 32'd100);
    push_tick(32'd1);
    push_tick(32'd5);
    push_start(32'd0, 32'd0, 32'd0, 32'd0);
    push_tick(32'd99);
    push_cmd(tps_pkg::OP_ABORT, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    push_tick(32'd1);
    push_start(32'd0, 32'd0, 32'd5, 32'hFFFF_FFFF);
    push_tick(32'd4);
    push_tick(32'd1);
    push_start(32'd10, 32'd0, 32'd0, 32'd0);
    push_cmd(tps_pkg::OP_NONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    push_tick(32'h8000_0000);
    push_start(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    push_cmd(tps_pkg::OP_ABORT, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
             32'h5555_5555, 32'h5555_5555);

    // Random part: mostly full runs with random timing, the rest noise.
    while (cmd_q.size() < 1824) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        push_start(pick_len(), pick_len(), pick_len(), pick_cool());
        burst = $urandom_range(1, 8);
        for (int i = 0; i < burst; i++) begin
          r = $urandom_range(0, 99);
          if (r < 80) push_tick(pick_delta());
          else if (r < 87) push_start(pick_len(), pick_len(), pick_len(), pick_cool());
          else if (r < 93) push_cmd(tps_pkg::OP_ABORT, $urandom, $urandom, $urandom,
                                    $urandom, $urandom);
          else push_cmd(tps_pkg::OP_NONE, $urandom, $urandom, $urandom, $urandom,
                        $urandom);
        end
      end else begin
        push_cmd(tps_pkg::opcode_e'($urandom_range(0, 3)), pick_delta(), $urandom,
                 $urandom, $urandom, $urandom);
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || in_valid_i || status_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
